[hdl/mlps_pkg.sv]
// Shared types, constants and the sigmoid table of the sigmoid network block.
package mlps_pkg;

  localparam int OP_W       = 2;
  localparam int IDX_W      = 10;
  localparam int VAL_W      = 16;
  localparam int ACT_W      = 13;
  localparam int OIDX_W     = 4;
  localparam int LC_W       = 3;
  localparam int SZ_W       = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int RESULT_CAP = 16;
  localparam int POS_W      = 8;
  localparam int WCNT_W     = 12;
  localparam int ACC_W      = 26;
  localparam int PROD_W     = 32;
  localparam int FRAC_W     = 12;
  localparam int SIG_DEPTH  = 256;
  localparam int SIG_IDX_W  = 8;

  localparam logic [OP_W-1:0] OP_WEIGHT = 2'd0;
  localparam logic [OP_W-1:0] OP_NEURON = 2'd1;
  localparam logic [OP_W-1:0] OP_RUN    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE0       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE1       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE2       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE3       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS        = 3'd5;

  localparam logic [63:0] EXP_STEP_Q30 = 64'd1040706261;

  typedef struct packed {
    logic [LC_W-1:0]            layer_count;
    logic [3:0][SZ_W-1:0]       size;
    logic signed [VAL_W-1:0]    bias;
  } cfg_t;

  // One multiply-accumulate term on its way from the sequencer to the datapath.
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             n_ok;
    logic             w_ok;
    logic             dst_ok;
    logic [POS_W-1:0] dst;
  } term_t;

  typedef struct packed {
    logic             we;
    logic [POS_W-1:0] addr;
    logic [VAL_W-1:0] data;
  } nwb_t;

  typedef logic [SIG_DEPTH-1:0][ACT_W-1:0] sig_table_t;

  function automatic logic [SZ_W-1:0] clamp_size(logic [SZ_W-1:0] s, int width_cap);
    if (s == '0) return SZ_W'(1);
    if (int'(s) > width_cap) return SZ_W'(width_cap);
    return s;
  endfunction

  // Entry k is the sigmoid of the bin centre (2k - 255) / 32 in Q.12. The
  // powers of e^(-1/32) are built by repeated rounded multiplication, and the
  // reciprocal by shift-and-subtract long division. Evaluated at elaboration.
  function automatic sig_table_t build_sig_table();
    logic [63:0] e;
    logic [63:0] etab [SIG_DEPTH/2];
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] q;
    int          i;
    int          k;
    int          b;
    int          t;
    sig_table_t  tab;
    e = 64'd1 << 30;
    for (i = 1; i < SIG_DEPTH; i++) begin
      e = (e * EXP_STEP_Q30 + (64'd1 << 29)) >> 30;
      if (i[0]) etab[i >> 1] = e;
    end
    for (k = 0; k < SIG_DEPTH; k++) begin
      t = (k >= SIG_DEPTH / 2) ? (2 * k - (SIG_DEPTH - 1)) : ((SIG_DEPTH - 1) - 2 * k);
      den = (64'd1 << 30) + etab[t >> 1];
      num = (64'd1 << 42) + (den >> 1);
      rem = '0;
      q   = '0;
      for (b = 42; b >= 0; b--) begin
        rem = (rem << 1) | {63'd0, num[b]};
        if (rem >= den) begin
          rem  = rem - den;
          q[b] = 1'b1;
        end
      end
      tab[k] = (k >= SIG_DEPTH / 2) ? q[ACT_W-1:0] : ACT_W'(64'd4096 - q);
    end
    return tab;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

[hdl/mlp_sigmoid_inference.sv]
// Top level of the sigmoid network forward-pass block.
//
// Input channel (in_valid / in_stall, fields op, index, value): op 0 writes a
// Q4.12 weight, op 1 writes an input-layer neuron, op 2 starts a forward
// pass and op 3 is ignored. An item is taken when in_valid is high and
// in_stall is low; in_stall is high for the whole run.
// Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) is always
// ready and writes layer_count, size_layer0..3 and bias_value in that order.
// Output channel (out_valid / out_stall): one item per output-layer neuron,
// at most sixteen, with last on the final one. A stalled item holds.
// For each computed layer the single shared multiply-accumulate takes one
// weight per cycle, prev_size * cur_size weights in all, then drains the
// read, multiply, accumulate, saturate and table-lookup stages before the next
// layer reads the values just written. Each result is then read from neuron
// memory before it is offered, and waits while the receiver stalls.
// Reset clears the control state and sets the registers to three layers of
// sixteen neurons and a bias of 1.0; both memories hold nothing defined until
// written and need no clearing pass.
module mlp_sigmoid_inference #(
  parameter int MAX_LAYERS   = 4,
  parameter int MAX_WIDTH    = 16,
  parameter int WEIGHT_DEPTH = 1024,
  parameter int NEURON_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mlps_pkg::OP_W-1:0]         op,
  input  logic [mlps_pkg::IDX_W-1:0]        index,
  input  logic signed [mlps_pkg::VAL_W-1:0] value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mlps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mlps_pkg::VAL_W-1:0]        cfg_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mlps_pkg::OIDX_W-1:0]       out_index,
  output logic [mlps_pkg::ACT_W-1:0]        out_value,
  output logic                              last
);

  localparam int NA_W = $clog2(NEURON_DEPTH);
  localparam int WA_W = $clog2(WEIGHT_DEPTH);

  mlps_pkg::cfg_t                  cfg;
  mlps_pkg::term_t                 term;
  mlps_pkg::nwb_t                  wb;
  logic                            busy;
  logic                            in_acc;
  logic                            load_wgt;
  logic                            load_nrn;
  logic [mlps_pkg::SZ_W-1:0]       size0;
  logic [NA_W-1:0]                 nrn_raddr;
  logic [NA_W-1:0]                 nrn_waddr;
  logic [mlps_pkg::VAL_W-1:0]      nrn_wdata;
  logic [mlps_pkg::VAL_W-1:0]      nrn_rdata;
  logic [WA_W-1:0]                 wgt_raddr;
  logic [mlps_pkg::VAL_W-1:0]      wgt_rdata;

  // Configuration registers. Write them only while the block is idle (unchecked).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.layer_count <= mlps_pkg::LC_W'(3);
      cfg.size[0]     <= mlps_pkg::SZ_W'(16);
      cfg.size[1]     <= mlps_pkg::SZ_W'(16);
      cfg.size[2]     <= mlps_pkg::SZ_W'(16);
      cfg.size[3]     <= mlps_pkg::SZ_W'(16);
      cfg.bias        <= 16'sd4096;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mlps_pkg::CFG_LAYER_COUNT: cfg.layer_count <= cfg_data[mlps_pkg::LC_W-1:0];
        mlps_pkg::CFG_SIZE0:       cfg.size[0]     <= cfg_data[mlps_pkg::SZ_W-1:0];
        mlps_pkg::CFG_SIZE1:       cfg.size[1]     <= cfg_data[mlps_pkg::SZ_W-1:0];
        mlps_pkg::CFG_SIZE2:       cfg.size[2]     <= cfg_data[mlps_pkg::SZ_W-1:0];
        mlps_pkg::CFG_SIZE3:       cfg.size[3]     <= cfg_data[mlps_pkg::SZ_W-1:0];
        mlps_pkg::CFG_BIAS:        cfg.bias        <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  // Load items write straight into the memories. An input neuron beyond the
  // configured input layer, or any address beyond a memory, is dropped.
  assign in_acc   = in_valid && !in_stall;
  assign size0    = mlps_pkg::clamp_size(cfg.size[0], MAX_WIDTH);
  assign load_wgt = in_acc && (op == mlps_pkg::OP_WEIGHT) && (int'(index) < WEIGHT_DEPTH);
  assign load_nrn = in_acc && (op == mlps_pkg::OP_NEURON) &&
                    (int'(index) < int'(size0)) && (int'(index) < NEURON_DEPTH);

  // The datapath writes computed neurons only during a run, when no load is taken.
  assign nrn_waddr = wb.we ? NA_W'(wb.addr) : NA_W'(index);
  assign nrn_wdata = wb.we ? wb.data : value;

  mlps_ram #(
    .WIDTH (mlps_pkg::VAL_W),
    .DEPTH (WEIGHT_DEPTH)
  ) u_wgt_ram (
    .clk   (clk),
    .we    (load_wgt),
    .waddr (WA_W'(index)),
    .wdata (value),
    .raddr (wgt_raddr),
    .rdata (wgt_rdata)
  );

  mlps_ram #(
    .WIDTH (mlps_pkg::VAL_W),
    .DEPTH (NEURON_DEPTH)
  ) u_nrn_ram (
    .clk   (clk),
    .we    (load_nrn || wb.we),
    .waddr (nrn_waddr),
    .wdata (nrn_wdata),
    .raddr (nrn_raddr),
    .rdata (nrn_rdata)
  );

  mlps_ctrl #(
    .MAX_LAYERS   (MAX_LAYERS),
    .MAX_WIDTH    (MAX_WIDTH),
    .WEIGHT_DEPTH (WEIGHT_DEPTH),
    .NEURON_DEPTH (NEURON_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .op        (op),
    .in_stall  (in_stall),
    .busy      (busy),
    .term      (term),
    .nrn_raddr (nrn_raddr),
    .wgt_raddr (wgt_raddr),
    .nrn_rdata (nrn_rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_index (out_index),
    .out_value (out_value),
    .last      (last)
  );

  mlps_neuron u_neuron (
    .clk       (clk),
    .rst       (rst),
    .bias      (cfg.bias),
    .term      (term),
    .nrn_rdata (nrn_rdata),
    .wgt_rdata (wgt_rdata),
    .busy      (busy),
    .wb        (wb)
  );

endmodule

[hdl/mlps_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module mlps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

[hdl/mlps_neuron.sv]
// Multiply-accumulate, bias, saturation and sigmoid lookup for one neuron stream.
module mlps_neuron (
  input  logic                           clk,
  input  logic                           rst,
  input  logic signed [mlps_pkg::VAL_W-1:0] bias,
  input  mlps_pkg::term_t                term,
  input  logic [mlps_pkg::VAL_W-1:0]     nrn_rdata,
  input  logic [mlps_pkg::VAL_W-1:0]     wgt_rdata,
  output logic                           busy,
  output mlps_pkg::nwb_t                 wb
);

  localparam int ACC_W = mlps_pkg::ACC_W;

  mlps_pkg::term_t                        t1;
  logic signed [mlps_pkg::VAL_W-1:0]      nv;
  logic signed [mlps_pkg::VAL_W-1:0]      wv;

  logic                                   v2;
  logic                                   first2;
  logic                                   last2;
  logic                                   ok2;
  logic [mlps_pkg::POS_W-1:0]             dst2;
  logic signed [mlps_pkg::PROD_W-1:0]     prod;

  logic signed [ACC_W-1:0]                acc;
  logic signed [ACC_W-1:0]                acc_next;
  logic signed [ACC_W-1:0]                prod_term;

  logic                                   v3;
  logic                                   ok3;
  logic [mlps_pkg::POS_W-1:0]             dst3;
  logic signed [ACC_W-1:0]                fin;
  logic signed [ACC_W-1:0]                sum;
  logic [mlps_pkg::VAL_W-1:0]             sat;

  logic                                   v4;
  logic                                   ok4;
  logic [mlps_pkg::POS_W-1:0]             dst4;
  logic [mlps_pkg::SIG_IDX_W-1:0]         idx4;

  assign nv = t1.n_ok ? signed'(nrn_rdata) : '0;
  assign wv = t1.w_ok ? signed'(wgt_rdata) : '0;

  // Arithmetic shift right rounds towards minus infinity, as the Q.12 scaling needs.
  assign prod_term = ACC_W'(prod >>> mlps_pkg::FRAC_W);
  assign acc_next  = (first2 ? '0 : acc) + prod_term;
  assign sum       = fin + ACC_W'(bias);

  always_comb begin
    if (sum > ACC_W'(32767)) sat = 16'h7fff;
    else if (sum < -ACC_W'(32768)) sat = 16'h8000;
    else sat = sum[mlps_pkg::VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1.valid <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
    end else begin
      t1.valid <= term.valid;
      v2       <= t1.valid;
      v3       <= v2 && last2;
      v4       <= v3;
    end
    t1.first  <= term.first;
    t1.last   <= term.last;
    t1.n_ok   <= term.n_ok;
    t1.w_ok   <= term.w_ok;
    t1.dst_ok <= term.dst_ok;
    t1.dst    <= term.dst;

    prod   <= nv * wv;
    first2 <= t1.first;
    last2  <= t1.last;
    ok2    <= t1.dst_ok;
    dst2   <= t1.dst;

    if (v2) acc <= acc_next;
    if (v2 && last2) begin
      fin  <= acc_next;
      ok3  <= ok2;
      dst3 <= dst2;
    end

    // Adding 32768 to the saturated sum only flips its sign bit.
    idx4 <= {~sat[15], sat[14:8]};
    ok4  <= ok3;
    dst4 <= dst3;
  end

  assign busy    = t1.valid || v2 || v3 || v4;
  assign wb.we   = v4 && ok4;
  assign wb.addr = dst4;
  assign wb.data = mlps_pkg::VAL_W'(mlps_pkg::SIG_TABLE[idx4]);

endmodule

[hdl/mlps_ctrl.sv]
// Sequencer: walks layers, neurons and weights, drains between layers, emits results.
module mlps_ctrl #(
  parameter int MAX_LAYERS   = 4,
  parameter int MAX_WIDTH    = 16,
  parameter int WEIGHT_DEPTH = 1024,
  parameter int NEURON_DEPTH = 64,
  localparam int NA_W = $clog2(NEURON_DEPTH),
  localparam int WA_W = $clog2(WEIGHT_DEPTH)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mlps_pkg::cfg_t                   cfg,
  input  logic                             in_valid,
  input  logic [mlps_pkg::OP_W-1:0]        op,
  output logic                             in_stall,
  input  logic                             busy,
  output mlps_pkg::term_t                  term,
  output logic [NA_W-1:0]                  nrn_raddr,
  output logic [WA_W-1:0]                  wgt_raddr,
  input  logic [mlps_pkg::VAL_W-1:0]       nrn_rdata,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mlps_pkg::OIDX_W-1:0]      out_index,
  output logic [mlps_pkg::ACT_W-1:0]       out_value,
  output logic                             last
);

  localparam int LAYER_CAP = (MAX_LAYERS < 4) ? MAX_LAYERS : 4;
  localparam int SZ_W      = mlps_pkg::SZ_W;
  localparam int LC_W      = mlps_pkg::LC_W;
  localparam int POS_W     = mlps_pkg::POS_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_OUT_RD,
    ST_OUT_LD
  } state_t;

  state_t                     state;
  logic [LC_W-1:0]            lyr;
  logic [LC_W-1:0]            nlyr;
  logic [LC_W-1:0]            nl;
  logic [POS_W-1:0]           pos;
  logic [SZ_W-1:0]            prev;
  logic [SZ_W-1:0]            cur;
  logic [SZ_W-1:0]            n;
  logic [SZ_W-1:0]            j;
  logic [SZ_W-1:0]            ocnt;
  logic [mlps_pkg::WCNT_W-1:0] w;
  logic                       rd_ok;
  logic [POS_W-1:0]           src;
  logic [POS_W-1:0]           dst;
  logic                       run_go;

  function automatic logic [SZ_W-1:0] size_of(logic [LC_W-1:0] l);
    logic [SZ_W-1:0] s;
    case (l)
      3'd0:    s = cfg.size[0];
      3'd1:    s = cfg.size[1];
      3'd2:    s = cfg.size[2];
      default: s = cfg.size[3];
    endcase
    return mlps_pkg::clamp_size(s, MAX_WIDTH);
  endfunction

  always_comb begin
    nl = cfg.layer_count;
    if (nl < LC_W'(2)) nl = LC_W'(2);
    if (int'(nl) > LAYER_CAP) nl = LC_W'(LAYER_CAP);
  end

  assign src    = pos - POS_W'(prev) + POS_W'(j);
  assign dst    = pos + POS_W'(n);
  assign run_go = in_valid && !in_stall && (op == mlps_pkg::OP_RUN);

  assign in_stall     = (state != ST_IDLE);
  assign term.valid   = (state == ST_ISSUE);
  assign term.first   = (j == '0);
  assign term.last    = (j == prev - SZ_W'(1));
  assign term.n_ok    = int'(src) < NEURON_DEPTH;
  assign term.w_ok    = int'(w) < WEIGHT_DEPTH;
  assign term.dst_ok  = int'(dst) < NEURON_DEPTH;
  assign term.dst     = dst;
  assign nrn_raddr    = (state == ST_ISSUE) ? NA_W'(src) : NA_W'(dst);
  assign wgt_raddr    = WA_W'(w);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (run_go) begin
            lyr   <= LC_W'(1);
            nlyr  <= nl;
            prev  <= size_of(LC_W'(0));
            cur   <= size_of(LC_W'(1));
            pos   <= POS_W'(size_of(LC_W'(0)));
            n     <= '0;
            j     <= '0;
            w     <= '0;
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          w <= w + 1'b1;
          if (j == prev - SZ_W'(1)) begin
            j <= '0;
            if (n == cur - SZ_W'(1)) state <= ST_DRAIN;
            else n <= n + 1'b1;
          end else begin
            j <= j + 1'b1;
          end
        end
        ST_DRAIN: begin
          // The next layer reads what this one writes, so the datapath empties first.
          if (!busy) begin
            n <= '0;
            if (lyr + LC_W'(1) < nlyr) begin
              lyr   <= lyr + LC_W'(1);
              prev  <= cur;
              cur   <= size_of(lyr + LC_W'(1));
              pos   <= pos + POS_W'(cur);
              state <= ST_ISSUE;
            end else begin
              ocnt  <= (cur > SZ_W'(mlps_pkg::RESULT_CAP)) ? SZ_W'(mlps_pkg::RESULT_CAP) : cur;
              state <= ST_OUT_RD;
            end
          end
        end
        ST_OUT_RD: begin
          if (!out_valid || !out_stall) begin
            rd_ok <= int'(dst) < NEURON_DEPTH;
            state <= ST_OUT_LD;
          end
        end
        ST_OUT_LD: begin
          out_valid <= 1'b1;
          out_index <= mlps_pkg::OIDX_W'(n);
          out_value <= rd_ok ? nrn_rdata[mlps_pkg::ACT_W-1:0] : '0;
          last      <= (n == ocnt - SZ_W'(1));
          if (n == ocnt - SZ_W'(1)) begin
            state <= ST_IDLE;
          end else begin
            n     <= n + 1'b1;
            state <= ST_OUT_RD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_after_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT_RD || state == ST_IDLE) |-> !busy)
    else $error("datapath still busy while results are read out");
  a_term_burst: assert property (@(posedge clk) disable iff (rst)
    (term.valid && !term.first) |-> $past(term.valid))
    else $error("continuation term without a preceding term");
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT_LD) |=> out_valid)
    else $error("result register not loaded after output read");
`endif

endmodule

[tb/sv/mlps_checker.sv]
// Checker for the sigmoid network block: predicts every forward pass and compares its results.
`timescale 1ns / 100ps

module mlps_checker
  import mlps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [OP_W-1:0]      op,
  input  logic [IDX_W-1:0]     index,
  input  logic [VAL_W-1:0]     value,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [OIDX_W-1:0]    out_index,
  input  logic [ACT_W-1:0]     out_value,
  input  logic                 last,
  output int                   fail_count,
  output int                   pending
);

  localparam int LAYER_CAP   = 4;
  localparam int WIDTH_CAP   = 16;
  localparam int WEIGHT_SLOTS = 1024;
  localparam int NEURON_SLOTS = 64;
  localparam longint unsigned DECAY_Q30 = 64'd1040706261;

  typedef struct packed {
    logic [OIDX_W-1:0] pos;
    logic [ACT_W-1:0]  act;
    logic              last_mark;
  } activation_t;

  logic [ACT_W-1:0]  sigmoid_lut [256];
  logic [VAL_W-1:0]  weight_mem [WEIGHT_SLOTS];
  logic [VAL_W-1:0]  neuron_mem [NEURON_SLOTS];
  logic [LC_W-1:0]   layer_count_reg;
  logic [SZ_W-1:0]   size_reg [4];
  logic [VAL_W-1:0]  bias_reg;
  activation_t       expected_acts [$];

  // Sigmoid of each bin centre, from rounded powers of e^(-1/32) in Q30.
  initial begin : build_lut
    longint unsigned e;
    longint unsigned den;
    longint unsigned p;
    int k;
    int t;
    int i;
    for (k = 0; k < 256; k++) begin
      t = (2 * k < 255) ? 255 - 2 * k : 2 * k - 255;
      e = 64'd1 << 30;
      for (i = 0; i < t; i++)
        e = (e * DECAY_Q30 + (64'd1 << 29)) >> 30;
      den = (64'd1 << 30) + e;
      p = ((64'd1 << 42) + den / 2) / den;
      sigmoid_lut[k] = (k >= 128) ? ACT_W'(p) : ACT_W'(64'd4096 - p);
    end
  end

  function automatic int fit_size(logic [SZ_W-1:0] s);
    if (s == '0) return 1;
    if (int'(s) > WIDTH_CAP) return WIDTH_CAP;
    return int'(s);
  endfunction

  function automatic int layers_in_use();
    if (layer_count_reg < 2) return 2;
    if (int'(layer_count_reg) > LAYER_CAP) return LAYER_CAP;
    return int'(layer_count_reg);
  endfunction

  // Walks every layer after the input layer, storing each activation so the
  // next layer can read it, then queues the output layer.
  function automatic void predict_pass();
    int n_layers;
    int l;
    int n;
    int j;
    int pos;
    int prev;
    int cur;
    int w;
    int cnt;
    int prod;
    int acc;
    n_layers = layers_in_use();
    pos = 0;
    w = 0;
    for (l = 1; l < n_layers; l++) begin
      prev = fit_size(size_reg[l-1]);
      cur = fit_size(size_reg[l]);
      pos += prev;
      for (n = 0; n < cur; n++) begin
        acc = 0;
        for (j = 0; j < prev; j++) begin
          prod = $signed(neuron_mem[pos - prev + j]) * $signed(weight_mem[w]);
          acc += prod >>> FRAC_W;
          w++;
        end
        acc += $signed(bias_reg);
        if (acc > 32767) acc = 32767;
        if (acc < -32768) acc = -32768;
        neuron_mem[pos + n] = VAL_W'(sigmoid_lut[(acc + 32768) >> 8]);
      end
    end
    cnt = fit_size(size_reg[n_layers-1]);
    for (n = 0; n < cnt; n++)
      expected_acts.push_back('{OIDX_W'(n), neuron_mem[pos + n][ACT_W-1:0], n == cnt - 1});
  endfunction

  always @(posedge clk) begin
    activation_t want;
    activation_t got;
    if (rst) begin
      layer_count_reg = 3'd3;
      size_reg[0] = 5'd16;
      size_reg[1] = 5'd16;
      size_reg[2] = 5'd16;
      size_reg[3] = 5'd16;
      bias_reg = 16'h1000;
      expected_acts.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LAYER_COUNT: layer_count_reg = cfg_data[LC_W-1:0];
          CFG_SIZE0:       size_reg[0] = cfg_data[SZ_W-1:0];
          CFG_SIZE1:       size_reg[1] = cfg_data[SZ_W-1:0];
          CFG_SIZE2:       size_reg[2] = cfg_data[SZ_W-1:0];
          CFG_SIZE3:       size_reg[3] = cfg_data[SZ_W-1:0];
          CFG_BIAS:        bias_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (op)
          OP_WEIGHT: weight_mem[index] = value;
          OP_NEURON: if (int'(index) < fit_size(size_reg[0])) neuron_mem[index] = value;
          OP_RUN:    predict_pass();
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{out_index, out_value, last};
        if (expected_acts.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual index %0d value %0d last %0b",
                   $time, out_index, out_value, last);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_acts.pop_front();
          if (got !== want) begin
            $display("%0t: index expected %0d actual %0d, value expected %0d actual %0d,",
                     $time, want.pos, got.pos, want.act, got.act,
                     " last expected %0b actual %0b", want.last_mark, got.last_mark);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= expected_acts.size();
  end

endmodule

[tb/sv/testbench.sv]
// Top of the testbench: drives items and settings into the sigmoid network block and gives the verdict.
`timescale 1ns / 100ps

module testbench;
  import mlps_pkg::*;

  // Op code and register indexes that the block is expected to ignore.
  localparam logic [OP_W-1:0]      OP_IGNORED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  // The weight budget keeps every forward pass short while still letting any
  // single layer reach the full width of sixteen.
  localparam int WEIGHT_BUDGET = 96;
  localparam int ITEM_TARGET   = 430;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      op = '0;
  logic [IDX_W-1:0]     index = '0;
  logic [VAL_W-1:0]     value = '0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0]     cfg_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [OIDX_W-1:0]    out_index;
  logic [ACT_W-1:0]     out_value;
  logic                 last;

  int fail_count;
  int pending;

  // Shadow of the settings as written, so the stimulus knows which weights and
  // input neurons a forward pass will read.
  logic [LC_W-1:0]  lc_raw;
  logic [SZ_W-1:0]  sz_raw [4];
  logic [VAL_W-1:0] bias_raw;

  // Store entries already written since reset. A pass is only started once
  // every entry it reads has been written at least once.
  bit w_loaded [1024];
  bit n_loaded [16];

  int items_sent = 0;
  int burst_left = 0;

  int       stall_left = 0;
  int       stall_mode = 0;
  bit [7:0] stall_tick = '0;

  mlp_sigmoid_inference u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .index     (index),
    .value     (value),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_index (out_index),
    .out_value (out_value),
    .last      (last)
  );

  mlps_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .index      (index),
    .value      (value),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_index  (out_index),
    .out_value  (out_value),
    .last       (last),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Backstop: a healthy run finishes in well under a tenth of this time.
  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // The receiver moves between four moods: never stalling, stalling at random,
  // stalling one cycle in four, and long stalls while tick bit four is set.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      0:       out_stall = 1'b0;
      1:       out_stall = ($urandom_range(0, 99) < 35);
      2:       out_stall = (stall_tick[1:0] == 2'b01);
      default: out_stall = stall_tick[4];
    endcase
  end

  function automatic int eff_size(int l);
    if (sz_raw[l] == '0) return 1;
    if (int'(sz_raw[l]) > 16) return 16;
    return int'(sz_raw[l]);
  endfunction

  function automatic int eff_layers();
    if (lc_raw < 2) return 2;
    if (lc_raw > 4) return 4;
    return int'(lc_raw);
  endfunction

  // Number of weights that one forward pass reads, from index 0 upwards.
  function automatic int weight_span();
    int total;
    int l;
    total = 0;
    for (l = 1; l < eff_layers(); l++)
      total += eff_size(l - 1) * eff_size(l);
    return total;
  endfunction

  // Half of the values span the whole Q4.12 range; the rest stay within
  // plus or minus two so that sums often land away from saturation.
  function automatic logic [VAL_W-1:0] rand_fixed();
    if ($urandom_range(0, 1) == 0) return VAL_W'($urandom);
    return VAL_W'($urandom_range(0, 16383) - 8192);
  endfunction

  // A register word, now and then with junk in the bits above the field.
  function automatic logic [VAL_W-1:0] reg_word(logic [VAL_W-1:0] field, int width);
    logic [VAL_W-1:0] word;
    word = ($urandom_range(0, 2) == 0) ? VAL_W'($urandom) : '0;
    word = (word >> width) << width;
    return word | field;
  endfunction

  // Offers one item. The sender works in bursts; between bursts it may drop
  // valid for a random gap, and half of the bursts follow straight on.
  task automatic push_item(input logic [OP_W-1:0] o, input logic [IDX_W-1:0] ix,
                           input logic [VAL_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    op = o;
    index = ix;
    value = v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic load_weight(input int ix, input logic [VAL_W-1:0] v);
    push_item(OP_WEIGHT, IDX_W'(ix), v);
    w_loaded[ix] = 1'b1;
    items_sent++;
  endtask

  // Writes beyond the input layer are dropped by the block, so they are
  // neither recorded nor counted.
  task automatic load_input(input int ix, input logic [VAL_W-1:0] v);
    push_item(OP_NEURON, IDX_W'(ix), v);
    if (ix < eff_size(0)) begin
      n_loaded[ix] = 1'b1;
      items_sent++;
    end
  endtask

  // Fills any entry the pass would read that has never been written, then
  // starts the pass. The index and value of a run item carry no meaning.
  task automatic run_pass();
    int i;
    for (i = 0; i < weight_span(); i++)
      if (!w_loaded[i]) load_weight(i, rand_fixed());
    for (i = 0; i < eff_size(0); i++)
      if (!n_loaded[i]) load_input(i, rand_fixed());
    push_item(OP_RUN, IDX_W'($urandom), VAL_W'($urandom));
    items_sent++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all_regs();
    cfg_write(CFG_LAYER_COUNT, reg_word(VAL_W'(lc_raw), LC_W));
    cfg_write(CFG_SIZE0, reg_word(VAL_W'(sz_raw[0]), SZ_W));
    cfg_write(CFG_SIZE1, reg_word(VAL_W'(sz_raw[1]), SZ_W));
    cfg_write(CFG_SIZE2, reg_word(VAL_W'(sz_raw[2]), SZ_W));
    cfg_write(CFG_SIZE3, reg_word(VAL_W'(sz_raw[3]), SZ_W));
    cfg_write(CFG_BIAS, bias_raw);
  endtask

  // Waits until every expected result has come back, then waits on so that
  // any load still in flight can finish.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Picks a fresh setting. Layer counts cover the whole field, so values
  // below two and above four are clamped by the block; sizes of zero and
  // above sixteen are clamped likewise. The draw is repeated until the pass
  // stays within the weight budget.
  task automatic new_setting();
    int l;
    int r;
    settle();
    lc_raw = LC_W'($urandom_range(0, 7));
    do begin
      for (l = 0; l < 4; l++) begin
        r = $urandom_range(0, 99);
        if (r < 10)      sz_raw[l] = '0;
        else if (r < 25) sz_raw[l] = SZ_W'($urandom_range(16, 31));
        else if (r < 35) sz_raw[l] = SZ_W'($urandom_range(5, 8));
        else             sz_raw[l] = SZ_W'($urandom_range(1, 4));
      end
    end while (weight_span() > WEIGHT_BUDGET);
    r = $urandom_range(0, 99);
    if (r < 15)      bias_raw = 16'h8000;
    else if (r < 30) bias_raw = 16'h7FFF;
    else if (r < 60) bias_raw = VAL_W'($urandom);
    else             bias_raw = VAL_W'($urandom_range(0, 8191) - 4096);
    write_all_regs();
    if ($urandom_range(0, 3) == 0) cfg_write(CFG_SPARE_A, VAL_W'($urandom));
  endtask

  initial begin : stimulus
    int n_eps;
    int n_w;
    int n_i;
    int i;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part. Two layers requested as one, so the count is clamped up;
    // an input layer of two neurons feeding three, and unused sizes of zero
    // and thirty-one. Writes to the spare register indexes must do nothing.
    lc_raw = 3'd1;
    sz_raw[0] = 5'd2;
    sz_raw[1] = 5'd3;
    sz_raw[2] = 5'd0;
    sz_raw[3] = 5'd31;
    bias_raw = 16'h0000;
    write_all_regs();
    cfg_write(CFG_SPARE_A, 16'hFFFF);
    cfg_write(CFG_SPARE_B, 16'h5A5A);

    // Extreme weights and inputs, a write to the top weight index, input
    // writes beyond the input layer and an unknown op, then a pass.
    load_weight(0, 16'h7FFF);
    load_weight(1, 16'h8000);
    load_weight(2, 16'h0000);
    load_weight(3, 16'hFFFF);
    load_weight(4, 16'h1000);
    load_weight(5, 16'hF000);
    load_input(0, 16'h1000);
    load_input(1, 16'hE000);
    load_input(2, 16'h7FFF);
    load_input(1023, 16'h8000);
    push_item(OP_IGNORED, 10'h3FF, 16'hFFFF);
    load_weight(1023, 16'h5555);
    run_pass();

    // Every product at its largest drives the sum into positive saturation;
    // the most negative inputs then drive it into negative saturation.
    for (i = 0; i < 6; i++) load_weight(i, 16'h7FFF);
    load_input(0, 16'h7FFF);
    load_input(1, 16'h7FFF);
    run_pass();
    load_input(0, 16'h8000);
    load_input(1, 16'h8000);
    run_pass();

    // Random part: each setting is followed by a handful of episodes, mostly
    // fresh weights and inputs ending in a pass, with some noise items and
    // now and then a batch of loads that is left without a pass.
    items_sent = 0;
    while (items_sent < ITEM_TARGET) begin
      new_setting();
      n_eps = $urandom_range(2, 6);
      repeat (n_eps) begin
        n_w = $urandom_range(0, 6);
        repeat (n_w) load_weight($urandom_range(0, weight_span() - 1), rand_fixed());
        n_i = $urandom_range(0, eff_size(0));
        repeat (n_i) load_input($urandom_range(0, eff_size(0) - 1), rand_fixed());
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 2))
            0:       push_item(OP_IGNORED, IDX_W'($urandom), VAL_W'($urandom));
            1:       load_input($urandom_range(eff_size(0), 1023), rand_fixed());
            default: load_weight($urandom_range(0, 1023), rand_fixed());
          endcase
        end
        if ($urandom_range(0, 9) != 0) run_pass();
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
